// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned StatW  = 2;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_ENQ  = 2'd0;
  localparam logic [ReqW-1:0] REQ_DEQ  = 2'd1;
  localparam logic [ReqW-1:0] REQ_SHOW = 2'd2;

  // Status codes.
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  // The operation that every cell of the chain performs.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ENQ,
    CELL_DEQ,
    CELL_ROT
  } cell_op_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic                tail_i,
  input  logic                ins_left_i,
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  input  spq_pkg::entry_t     head_i,
  output logic                ins_o,
  output spq_pkg::entry_t     entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // A new item goes ahead of the first entry with equal or greater priority.
  // Empty cells always count as insertion candidates, which keeps the flag
  // monotonic along the chain.
  assign ins_o = !occ_i || ($signed(entry_q.prio) >= $signed(ctrl_i.new_entry.prio));

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_ENQ: begin
        if (ins_o) begin
          entry_d = ins_left_i ? left_i : ctrl_i.new_entry;
        end
      end
      CELL_DEQ: begin
        entry_d = right_i;
      end
      CELL_ROT: begin
        if (occ_i) begin
          entry_d = tail_i ? head_i : right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue of up to DEPTH entries, kept in ascending order of
// priority so that the smallest priority value is served first. Among equal
// priorities the most recently enqueued entry is served first.
// A request is accepted at a rising edge where start is high and busy is
// low. req_type_i selects enqueue, dequeue or read-out; code 3 is ignored.
// Every result beat appears on the out_* ports for exactly one cycle, marked
// by out_valid_o, and is registered at the edge that produced it. The receiver
// cannot stall, so results never wait inside the block.
// Enqueue and dequeue can be issued back to back: the row of cells
// compares and shifts all entries in the same cycle.
// A read-out of N entries streams N beats without gaps and holds busy high
// from its acceptance until the edge that produces its last beat, as the
// chain rotates one entry through the head cell per cycle. An empty queue
// answers a dequeue or read-out with a single empty beat, and a full queue
// answers an enqueue with a single full beat and drops the item.
// Reset clears the entry count and any read-out in progress; the entry
// storage itself is not cleared, since only occupied cells are ever read.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [spq_pkg::ReqW-1:0]             req_type_i,
  input  logic signed [spq_pkg::ValueW-1:0]    item_value_i,
  input  logic signed [spq_pkg::PrioW-1:0]     item_priority_i,
  output logic                                 out_valid_o,
  output logic signed [spq_pkg::ValueW-1:0]    out_value_o,
  output logic signed [spq_pkg::PrioW-1:0]     out_priority_o,
  output logic [spq_pkg::StatW-1:0]            status_o,
  output logic                                 last_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Control state: number of stored entries and the read-out sequencer.
  logic [CntW-1:0] count_q, count_d;
  logic            show_q, show_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            valid_q, valid_d;

  // Result beat registers.
  entry_t          res_q, res_d;
  logic [StatW-1:0] stat_q, stat_d;
  logic            last_q, last_d;

  cell_ctrl_t ctrl;
  entry_t     entries [DEPTH];
  logic       ins     [DEPTH];
  logic       accept;

  assign accept = start && !busy;
  assign busy   = show_q;

  // Controller: decides the chain operation and the result beat.
  always_comb begin
    count_d              = count_q;
    show_d               = show_q;
    rem_d                = rem_q;
    valid_d              = 1'b0;
    res_d                = '0;
    stat_d               = ST_OK;
    last_d               = 1'b1;
    ctrl.op              = CELL_HOLD;
    ctrl.new_entry.value = item_value_i;
    ctrl.new_entry.prio  = item_priority_i;

    if (show_q) begin
      // Read-out in progress: each cycle the head entry is emitted and the
      // occupied part of the chain rotates by one, so after all beats the
      // queue is back in its original order.
      ctrl.op = CELL_ROT;
      valid_d = 1'b1;
      res_d   = entries[0];
      last_d  = (rem_q == CntW'(1));
      rem_d   = rem_q - CntW'(1);
      if (rem_q == CntW'(1)) begin
        show_d = 1'b0;
      end
    end else if (accept) begin
      case (req_type_i)
        REQ_ENQ: begin
          valid_d = 1'b1;
          if (count_q == CntW'(DEPTH)) begin
            stat_d = ST_FULL;
          end else begin
            ctrl.op = CELL_ENQ;
            count_d = count_q + CntW'(1);
          end
        end
        REQ_DEQ: begin
          valid_d = 1'b1;
          if (count_q == '0) begin
            stat_d = ST_EMPTY;
          end else begin
            ctrl.op = CELL_DEQ;
            res_d   = entries[0];
            count_d = count_q - CntW'(1);
          end
        end
        REQ_SHOW: begin
          valid_d = 1'b1;
          if (count_q == '0) begin
            stat_d = ST_EMPTY;
          end else begin
            // The first beat leaves right away; the rest follow while busy.
            ctrl.op = CELL_ROT;
            res_d   = entries[0];
            last_d  = (count_q == CntW'(1));
            show_d  = (count_q != CntW'(1));
            rem_d   = count_q - CntW'(1);
          end
        end
        default: begin
          valid_d = 1'b0;
        end
      endcase
    end
  end

  // The row of cells. Cell 0 is the head; each cell sees its neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occ;
    logic   tail;
    logic   ins_left;
    entry_t left;
    entry_t right;

    // Cell i is occupied while i is below the entry count.
    assign occ  = (count_q > CntW'(i));
    assign tail = (count_q == CntW'(i + 1));

    if (i == 0) begin : g_head
      assign ins_left = 1'b0;
      assign left     = ctrl.new_entry;
    end else begin : g_body
      assign ins_left = ins[i-1];
      assign left     = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right = entries[i];
    end else begin : g_mid
      assign right = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ),
      .tail_i     (tail),
      .ins_left_i (ins_left),
      .left_i     (left),
      .right_i    (right),
      .head_i     (entries[0]),
      .ins_o      (ins[i]),
      .entry_o    (entries[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      show_q  <= 1'b0;
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      show_q  <= show_d;
      rem_q   <= rem_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

  assign out_valid_o    = valid_q;
  assign out_value_o    = res_q.value;
  assign out_priority_o = res_q.prio;
  assign status_o       = stat_q;
  assign last_o         = last_q;

endmodule

// ===== hw/rtl/spq_checker.sv =====
module spq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [spq_pkg::ReqW-1:0]    req_type_i,
  input logic                        out_valid_o,
  input logic [spq_pkg::StatW-1:0]   status_o,
  input logic                        last_o
);
  import spq_pkg::*;

  // Every accepted request with a defined code answers on the next cycle.
  a_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i == REQ_ENQ || req_type_i == REQ_DEQ ||
     req_type_i == REQ_SHOW)) |=> out_valid_o)
    else $error("accepted request gave no result beat");

  // The unused request code produces nothing.
  a_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !(req_type_i == REQ_ENQ || req_type_i == REQ_DEQ ||
     req_type_i == REQ_SHOW)) |=> !out_valid_o)
    else $error("ignored request code produced a beat");

  // While busy the read-out keeps streaming without gaps.
  a_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> out_valid_o)
    else $error("gap in read-out stream");

  // A beat that is not the last one means the read-out is still running.
  a_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> busy)
    else $error("non-final beat while not busy");

  // Empty and full answers are always single beats.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> last_o)
    else $error("error status on a non-final beat");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .status_o    (status_o),
  .last_o      (last_o)
);

// ===== dv/sorted_priority_queue_tb.sv =====
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned DEPTH = DefaultDepth;

  // The block ignores request code 3. It has no name in the package.
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [PrioW-1:0]  PRIO_MAX  = 16'sh7FFF;
  localparam logic signed [PrioW-1:0]  PRIO_MIN  = 16'sh8000;
  localparam logic signed [ValueW-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ValueW-1:0] VALUE_MIN = 32'sh8000_0000;

  // In a correct run requests and result beats keep moving. Sender gaps are
  // bounded in send_request, and each result is registered at the edge that
  // takes its request, so this limit leaves a wide margin.
  localparam int unsigned STALL_LIMIT = 500;

  // After the last expected beat, the block gets this long to show any
  // extra beats that it should not produce.
  localparam int unsigned DRAIN_CYCLES = 20;

  // One result beat as the block should present it.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
    logic [StatW-1:0]         status;
    logic                     last;
  } beat_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [ReqW-1:0]          req_type_i;
  logic signed [ValueW-1:0] item_value_i;
  logic signed [PrioW-1:0]  item_priority_i;
  logic                     out_valid_o;
  logic signed [ValueW-1:0] out_value_o;
  logic signed [PrioW-1:0]  out_priority_o;
  logic [StatW-1:0]         status_o;
  logic                     last_o;

  // The entries that the queue should hold, head first, and the result beats
  // that are still owed by the block, oldest first.
  entry_t      queued_entries[$];
  beat_t       owed_beats[$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on      = 1'b1;

  sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .out_valid_o    (out_valid_o),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void owe_beat(input logic signed [ValueW-1:0] value,
                                   input logic signed [PrioW-1:0] prio,
                                   input logic [StatW-1:0] status, input logic last);
    beat_t b;
    b.value  = value;
    b.prio   = prio;
    b.status = status;
    b.last   = last;
    owed_beats.push_back(b);
  endfunction

  // Applies one accepted request to the mirror of the queue and records the
  // beats it should produce. A new entry goes ahead of the first stored entry
  // whose priority is equal or greater, so among equal priorities the newest
  // one is served first.
  function automatic void apply_request(input logic [ReqW-1:0] kind,
                                        input logic signed [ValueW-1:0] value,
                                        input logic signed [PrioW-1:0] prio);
    int     slot;
    entry_t fresh;
    entry_t head;
    case (kind)
      REQ_ENQ: begin
        if (queued_entries.size() >= DEPTH) begin
          owe_beat('0, '0, ST_FULL, 1'b1);
        end else begin
          slot = queued_entries.size();
          for (int i = 0; i < queued_entries.size(); i++) begin
            if ($signed(queued_entries[i].prio) >= $signed(prio)) begin
              slot = i;
              break;
            end
          end
          fresh.value = value;
          fresh.prio  = prio;
          queued_entries.insert(slot, fresh);
          owe_beat('0, '0, ST_OK, 1'b1);
        end
      end
      REQ_DEQ: begin
        if (queued_entries.size() == 0) begin
          owe_beat('0, '0, ST_EMPTY, 1'b1);
        end else begin
          head = queued_entries.pop_front();
          owe_beat(head.value, head.prio, ST_OK, 1'b1);
        end
      end
      REQ_SHOW: begin
        if (queued_entries.size() == 0) begin
          owe_beat('0, '0, ST_EMPTY, 1'b1);
        end else begin
          // The read-out leaves the queue as it is.
          for (int i = 0; i < queued_entries.size(); i++) begin
            owe_beat(queued_entries[i].value, queued_entries[i].prio, ST_OK,
                     i == queued_entries.size() - 1);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Presents one request and returns at the edge where it is taken. The
  // caller is always at a rising edge. When no gap is drawn, start simply
  // stays high from the previous beat, so it never gets two assignments in
  // the same time step.
  task automatic send_request(input logic [ReqW-1:0] kind,
                              input logic signed [ValueW-1:0] value,
                              input logic signed [PrioW-1:0] prio);
    if (gaps_on && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start           <= 1'b1;
    req_type_i      <= kind;
    item_value_i    <= value;
    item_priority_i <= prio;
    do @(posedge clk_i); while (busy);
    apply_request(kind, value, prio);
  endtask

  // Full-range priorities, a narrow_pct share of small ones that collide often,
  // and five percent at the two extremes.
  function automatic logic signed [PrioW-1:0] pick_priority(input int narrow_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return ($urandom_range(0, 1) != 0) ? PRIO_MAX : PRIO_MIN;
    if (roll < 5 + narrow_pct) return 16'($urandom_range(0, 6)) - 16'd3;
    return 16'($urandom);
  endfunction

  task automatic test_empty_queue();
    send_request(REQ_DEQ, 32'($urandom), 16'($urandom));
    send_request(REQ_SHOW, 32'($urandom), 16'($urandom));
  endtask

  // Code 3 must leave no beat and no trace in the queue.
  task automatic test_unused_code();
    send_request(REQ_UNUSED, 32'($urandom), 16'($urandom));
    send_request(REQ_DEQ, 32'($urandom), 16'($urandom));
  endtask

  // Extreme values and priorities, ties at both ends of the priority range
  // and in the middle, an ignored request on a non-empty queue, then a full
  // read-out and a drain down to an empty dequeue.
  task automatic test_extremes_and_ties();
    send_request(REQ_ENQ, VALUE_MAX, PRIO_MAX);
    send_request(REQ_ENQ, VALUE_MIN, PRIO_MIN);
    send_request(REQ_ENQ, '0, '0);
    send_request(REQ_ENQ, 32'sd1, '0);
    send_request(REQ_ENQ, -32'sd1, PRIO_MAX);
    send_request(REQ_ENQ, 32'sh5A5A_A5A5, PRIO_MIN);
    send_request(REQ_UNUSED, 32'($urandom), 16'($urandom));
    send_request(REQ_SHOW, 32'($urandom), 16'($urandom));
    repeat (6) send_request(REQ_DEQ, 32'($urandom), 16'($urandom));
    send_request(REQ_DEQ, 32'($urandom), 16'($urandom));
  endtask

  // Fills the queue, pushes two more items against the full queue, reads the
  // whole queue out, then drains it and asks once more on the empty queue.
  task automatic test_fill_to_full();
    gaps_on = 1'b1;
    while (queued_entries.size() < DEPTH) begin
      send_request(REQ_ENQ, 32'($urandom), pick_priority(50));
    end
    repeat (2) send_request(REQ_ENQ, 32'($urandom), pick_priority(50));
    send_request(REQ_SHOW, 32'($urandom), 16'($urandom));
    while (queued_entries.size() > 0) begin
      send_request(REQ_DEQ, 32'($urandom), 16'($urandom));
    end
    send_request(REQ_DEQ, 32'($urandom), 16'($urandom));
  endtask

  // Random mix of requests. The enqueue share steers the fill level; a few
  // ignored codes are mixed in and not counted toward the request total.
  task automatic test_random_traffic(input int requests, input int enq_pct,
                                     input int show_pct, input int narrow_pct,
                                     input bit with_gaps);
    int              sent;
    int              roll;
    logic [ReqW-1:0] kind;
    gaps_on = with_gaps;
    sent    = 0;
    while (sent < requests) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) kind = REQ_UNUSED;
      else if (roll < 3 + show_pct) kind = REQ_SHOW;
      else if (roll < 3 + show_pct + enq_pct) kind = REQ_ENQ;
      else kind = REQ_DEQ;
      send_request(kind, 32'($urandom), pick_priority(narrow_pct));
      if (kind != REQ_UNUSED) sent++;
    end
  endtask

  // Every result beat is taken at the edge that ends its cycle and checked
  // against the oldest owed beat.
  always @(posedge clk_i) begin : check_beats
    beat_t want;
    if (rst_ni && out_valid_o) begin
      if (owed_beats.size() == 0) begin
        error_count++;
        $error("unexpected beat: value %0d priority %0d status %0d last %0d",
               out_value_o, out_priority_o, status_o, last_o);
      end else begin
        want = owed_beats.pop_front();
        if (out_value_o !== want.value) begin
          error_count++;
          $error("out_value: expected %0d, got %0d", want.value, out_value_o);
        end
        if (out_priority_o !== want.prio) begin
          error_count++;
          $error("out_priority: expected %0d, got %0d", want.prio, out_priority_o);
        end
        if (status_o !== want.status) begin
          error_count++;
          $error("status: expected %0d, got %0d", want.status, status_o);
        end
        if (last_o !== want.last) begin
          error_count++;
          $error("last: expected %0d, got %0d", want.last, last_o);
        end
      end
    end
  end

  // Ends the run if neither a request nor a result beat moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = REQ_ENQ;
    item_value_i    = '0;
    item_priority_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_queue();
    test_unused_code();
    test_extremes_and_ties();
    // Mostly enqueues with many ties, so the queue runs up against full.
    test_random_traffic(60, 70, 8, 60, 1'b1);
    test_fill_to_full();
    // Mostly dequeues, so the queue keeps running dry.
    test_random_traffic(50, 30, 8, 20, 1'b1);
    // A long stretch with requests back to back.
    test_random_traffic(50, 50, 10, 50, 1'b0);
    // Read-out heavy with crowded priorities.
    test_random_traffic(40, 55, 15, 80, 1'b1);

    start <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
